FILE: design/tccc_pkg.sv
// Package: shared types and constants of the text console cursor controller
`timescale 1ns / 1ps
`default_nettype none
package tccc_pkg;

    // item kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_MOVE  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // control characters
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    // configuration register indexes
    localparam logic [2:0] REG_ENABLED   = 3'd0;
    localparam logic [2:0] REG_TEXT_COLS = 3'd1;
    localparam logic [2:0] REG_TEXT_ROWS = 3'd2;
    localparam logic [2:0] REG_FG_COLOR  = 3'd3;
    localparam logic [2:0] REG_BG_COLOR  = 3'd4;

    localparam logic [31:0] FG_RESET   = 32'h00FF_FFFF;
    localparam logic [6:0]  COL_MAX    = 7'd127;
    localparam int          TAB_STOP   = 4;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // renderer commands
    typedef enum logic [1:0] {
        CMD_DRAW   = 2'd0,
        CMD_SCROLL = 2'd1,
        CMD_FILL   = 2'd2
    } command_t;

    // one classified item: a run of cells, then an optional scroll or fill
    typedef struct packed {
        logic [2:0]  n_cells;
        logic        scroll;
        logic        fill;
        logic [7:0]  glyph;
        logic [6:0]  col;
        logic [5:0]  row;
        logic [31:0] fg;
        logic [31:0] bg;
    } job_t;

endpackage
`default_nettype wire

FILE: design/text_console_cursor_control_core.sv
// Top level: configuration registers and the front, queue and back of the console cursor controller
`timescale 1ns / 1ps
`default_nettype none
// Text console cursor controller. Items enter through push/full and renderer commands leave
// through empty/pop. The front takes one item per clock while the queue is not full, updates
// the cursor at once and writes a job for each item that gives commands into a four-entry queue;
// the back turns each job into its commands at one command per clock while the receiver pops,
// through a single output register. A character gives one or two commands, a tab up to four,
// newline and clear at most one, so the sustained rate is one item per clock as long as items
// produce no more than one command each and the receiver does not stall; the extra commands
// of tabs and wraps are absorbed by the queue. Results go from the queue to the output register.
// Configuration writes are always ready and take effect on the next item.
module text_console_cursor_control_core #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 48
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  char_code,
    input  wire logic [5:0]  target_row,
    input  wire logic [6:0]  target_col,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       command,
    output logic [7:0]       glyph_code,
    output logic [6:0]       cell_col,
    output logic [5:0]       cell_row,
    output logic [31:0]      draw_fg,
    output logic [31:0]      draw_bg,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import tccc_pkg::*;

    logic        enabled_reg;
    logic [7:0]  text_cols_reg;
    logic [5:0]  text_rows_reg;
    logic [31:0] fg_color_reg;
    logic [31:0] bg_color_reg;
    logic        accept;
    job_t        front_job;
    job_t        head_job;
    logic        job_write;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            text_cols_reg <= 8'd0;
            text_rows_reg <= 6'd0;
            fg_color_reg  <= FG_RESET;
            bg_color_reg  <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ENABLED:   enabled_reg   <= cfg_data[0];
                REG_TEXT_COLS: text_cols_reg <= cfg_data[7:0];
                REG_TEXT_ROWS: text_rows_reg <= cfg_data[5:0];
                REG_FG_COLOR:  fg_color_reg  <= cfg_data;
                REG_BG_COLOR:  bg_color_reg  <= cfg_data;
                default:       enabled_reg   <= enabled_reg;
            endcase
        end
    end

    // input transfer
    assign full   = q_full;
    assign accept = push && !q_full;

    tccc_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .kind       (kind),
        .char_code  (char_code),
        .target_row (target_row),
        .target_col (target_col),
        .enabled    (enabled_reg),
        .text_cols  (text_cols_reg),
        .text_rows  (text_rows_reg),
        .fg_color   (fg_color_reg),
        .bg_color   (bg_color_reg),
        .job        (front_job),
        .job_write  (job_write)
    );

    tccc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (job_write),
        .wr_job  (front_job),
        .rd      (q_pop),
        .rd_job  (head_job),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    tccc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (head_job),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .command    (command),
        .glyph_code (glyph_code),
        .cell_col   (cell_col),
        .cell_row   (cell_row),
        .draw_fg    (draw_fg),
        .draw_bg    (draw_bg),
        .last       (last)
    );

endmodule
`default_nettype wire

FILE: design/tccc_front.sv
// Front end: cursor state, item classification and job generation
`timescale 1ns / 1ps
`default_nettype none
module tccc_front #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 48
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  char_code,
    input  wire logic [5:0]  target_row,
    input  wire logic [6:0]  target_col,
    input  wire logic        enabled,
    input  wire logic [7:0]  text_cols,
    input  wire logic [5:0]  text_rows,
    input  wire logic [31:0] fg_color,
    input  wire logic [31:0] bg_color,
    output tccc_pkg::job_t   job,
    output logic             job_write
);
    import tccc_pkg::*;

    logic [5:0] row_reg, row_next;
    logic [6:0] col_reg, col_next;
    logic [8:0] cols_eff;
    logic [6:0] rows_eff;
    logic [6:0] nr_sum;
    logic       nr_scroll;
    logic [5:0] nr_row;
    logic [8:0] col_ext;
    logic [8:0] col_inc;
    logic [8:0] tab_room;
    logic [2:0] tab_dist;
    logic [2:0] tab_n;
    logic [7:0] tab_end;
    logic [6:0] tab_col;
    logic       has_result;

    // screen size clamped to the parameters
    assign cols_eff = ({1'b0, text_cols} < 9'(MAX_COLS)) ? {1'b0, text_cols} : 9'(MAX_COLS);
    assign rows_eff = ({1'b0, text_rows} < 7'(MAX_ROWS)) ? {1'b0, text_rows} : 7'(MAX_ROWS);

    // next row, scrolling past the bottom
    assign nr_sum    = {1'b0, row_reg} + 7'd1;
    assign nr_scroll = nr_sum >= rows_eff;
    assign nr_row    = nr_scroll ? ((rows_eff != 7'd0) ? 6'(rows_eff - 7'd1) : 6'd0)
                                 : nr_sum[5:0];

    // column advance for a printable character
    assign col_ext = {2'b00, col_reg};
    assign col_inc = col_ext + 9'd1;

    // tab run length: to the next stop, limited by the last column
    assign tab_dist = 3'(TAB_STOP) - {1'b0, col_reg[1:0]};
    assign tab_room = cols_eff - col_ext;
    assign tab_n    = (col_ext >= cols_eff) ? 3'd1 :
                      (tab_room < {6'd0, tab_dist}) ? tab_room[2:0] : tab_dist;
    assign tab_end  = {1'b0, col_reg} + {5'd0, tab_n};
    assign tab_col  = tab_end[7] ? COL_MAX : tab_end[6:0];

    // classification
    always_comb
    begin
        job         = '0;
        job.glyph   = char_code;
        job.col     = col_reg;
        job.row     = row_reg;
        job.fg      = fg_color;
        job.bg      = bg_color;
        has_result  = 1'b0;
        row_next    = row_reg;
        col_next    = col_reg;
        case (kind)
            KIND_MOVE:
            begin
                row_next = target_row;
                col_next = target_col;
            end
            KIND_CLEAR:
            begin
                if (enabled)
                begin
                    job.fill   = 1'b1;
                    has_result = 1'b1;
                    row_next   = 6'd0;
                    col_next   = 7'd0;
                end
            end
            KIND_CHAR:
            begin
                if (enabled)
                begin
                    case (char_code)
                        CH_NEWLINE:
                        begin
                            job.scroll = nr_scroll;
                            has_result = nr_scroll;
                            row_next   = nr_row;
                            col_next   = 7'd0;
                        end
                        CH_RETURN:
                        begin
                            col_next = 7'd0;
                        end
                        CH_BACKSPACE:
                        begin
                            if (col_reg != 7'd0)
                                col_next = col_reg - 7'd1;
                        end
                        CH_TAB:
                        begin
                            job.n_cells = tab_n;
                            job.glyph   = CH_SPACE;
                            has_result  = 1'b1;
                            col_next    = tab_col;
                        end
                        default:
                        begin
                            job.n_cells = 3'd1;
                            has_result  = 1'b1;
                            if (col_inc >= cols_eff)
                            begin
                                col_next   = 7'd0;
                                job.scroll = nr_scroll;
                                row_next   = nr_row;
                            end
                            else
                            begin
                                col_next = col_inc[7] ? COL_MAX : col_inc[6:0];
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                row_next = row_reg;
            end
        endcase
    end

    assign job_write = accept && has_result;

    // cursor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= 6'd0;
            col_reg <= 7'd0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/tccc_queue.sv
// Job queue: short register queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module tccc_queue (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr,
    input  wire tccc_pkg::job_t wr_job,
    input  wire logic      rd,
    output tccc_pkg::job_t rd_job,
    output logic           q_full,
    output logic           q_empty
);
    import tccc_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign q_full  = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign q_empty = count_reg == '0;
    assign rd_job  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W + 1)'(wr) - (QPTR_W + 1)'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

endmodule
`default_nettype wire

FILE: design/tccc_back.sv
// Back end: jobs to renderer commands in the output register, one per cycle unless stalled
`timescale 1ns / 1ps
`default_nettype none
module tccc_back (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire tccc_pkg::job_t job,
    input  wire logic        q_empty,
    output logic             q_pop,
    input  wire logic        pop,
    output logic             empty,
    output logic [1:0]       command,
    output logic [7:0]       glyph_code,
    output logic [6:0]       cell_col,
    output logic [5:0]       cell_row,
    output logic [31:0]      draw_fg,
    output logic [31:0]      draw_bg,
    output logic             last
);
    import tccc_pkg::*;

    logic [2:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  total;
    logic        advance;
    logic        is_last;
    logic        is_cell;
    command_t    cmd_sel;
    logic [1:0]  command_reg;
    logic [7:0]  glyph_reg;
    logic [6:0]  col_reg;
    logic [5:0]  row_reg;
    logic [31:0] fg_reg;
    logic [31:0] bg_reg;
    logic        last_reg;

    // result sequencing within the head job
    assign total   = job.n_cells + {2'b00, job.scroll} + {2'b00, job.fill};
    assign is_last = idx_reg == (total - 3'd1);
    assign is_cell = idx_reg < job.n_cells;
    assign advance = !q_empty && (!out_valid_reg || pop);
    assign q_pop   = advance && is_last;

    always_comb
    begin
        if (is_cell)
            cmd_sel = CMD_DRAW;
        else if (job.scroll)
            cmd_sel = CMD_SCROLL;
        else
            cmd_sel = CMD_FILL;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (advance)
            idx_next = is_last ? 3'd0 : idx_reg + 3'd1;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            command_reg <= cmd_sel;
            glyph_reg   <= is_cell ? job.glyph : 8'd0;
            col_reg     <= is_cell ? job.col + {5'd0, idx_reg[1:0]} : 7'd0;
            row_reg     <= is_cell ? job.row : 6'd0;
            fg_reg      <= is_cell ? job.fg : 32'd0;
            bg_reg      <= job.bg;
            last_reg    <= is_last;
        end
    end

    assign empty      = !out_valid_reg;
    assign command    = command_reg;
    assign glyph_code = glyph_reg;
    assign cell_col   = col_reg;
    assign cell_row   = row_reg;
    assign draw_fg    = fg_reg;
    assign draw_bg    = bg_reg;
    assign last       = last_reg;

    // a job leaves the queue only with its final result
    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (last && out_valid_reg))
        else $error("job retired without its final result");

    // the result index stays inside the head job
    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> (idx_reg < total))
        else $error("result index beyond job length");

    // a held result is not overwritten
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(bg_reg) && $stable(last_reg)))
        else $error("waiting result lost");

    // index returns to zero between jobs
    a_idx_reset: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (idx_reg == 3'd0))
        else $error("index not cleared after job");

endmodule
`default_nettype wire

FILE: dv/tccc_tb_pkg.sv
// Command record and cursor command tracker for the console cursor testbench
`timescale 1ns / 1ps
package tccc_tb_pkg;

    import tccc_pkg::*;

    // kind code that the block ignores
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // screen limits of the default build
    localparam int SCREEN_COLS_MAX = 128;
    localparam int SCREEN_ROWS_MAX = 48;

    // one renderer command as seen on the result ports
    typedef struct packed {
        command_t    cmd;
        logic [7:0]  glyph;
        logic [6:0]  col;
        logic [5:0]  row;
        logic [31:0] fg;
        logic [31:0] bg;
        logic        last;
    } cmd_rec_t;

    // tracks cursor and registers, and holds the commands still owed by the block
    class cursor_cmd_tracker;

        logic        enabled;
        logic [7:0]  text_cols;
        logic [5:0]  text_rows;
        logic [31:0] fg_color;
        logic [31:0] bg_color;
        logic [5:0]  row_pos;
        logic [6:0]  col_pos;
        cmd_rec_t    owed_cmds[$];
        int          n_fail;

        function new();
            enabled   = 1'b0;
            text_cols = 8'd0;
            text_rows = 6'd0;
            fg_color  = FG_RESET;
            bg_color  = 32'd0;
            row_pos   = 6'd0;
            col_pos   = 7'd0;
            n_fail    = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_ENABLED:   enabled   = data[0];
                REG_TEXT_COLS: text_cols = data[7:0];
                REG_TEXT_ROWS: text_rows = data[5:0];
                REG_FG_COLOR:  fg_color  = data;
                REG_BG_COLOR:  bg_color  = data;
                default: ;
            endcase
        endfunction

        function void add_cmd(command_t c, logic [7:0] g, int col, int row, logic [31:0] f);
            cmd_rec_t r;
            r.cmd   = c;
            r.glyph = g;
            r.col   = 7'(col);
            r.row   = 6'(row);
            r.fg    = f;
            r.bg    = bg_color;
            r.last  = 1'b0;
            owed_cmds.push_back(r);
        endfunction

        // step down one row, scrolling when past the bottom
        function void next_row(int rows);
            int nr;
            nr = row_pos + 1;
            if (nr >= rows)
            begin
                add_cmd(CMD_SCROLL, 8'd0, 0, 0, 32'd0);
                nr = (rows > 0) ? rows - 1 : 0;
            end
            row_pos = 6'(nr);
        endfunction

        // accepted input item: update cursor and queue the commands it causes
        function void note_item(logic [1:0] kind, logic [7:0] ch, logic [5:0] trow,
                                logic [6:0] tcol);
            int cols;
            int rows;
            int c;
            int k;
            int n0;
            cols = (text_cols < SCREEN_COLS_MAX) ? int'(text_cols) : SCREEN_COLS_MAX;
            rows = (text_rows < SCREEN_ROWS_MAX) ? int'(text_rows) : SCREEN_ROWS_MAX;
            n0   = owed_cmds.size();
            if (kind == KIND_MOVE)
            begin
                row_pos = trow;
                col_pos = tcol;
                return;
            end
            if (kind == KIND_UNUSED || !enabled)
                return;
            if (kind == KIND_CLEAR)
            begin
                add_cmd(CMD_FILL, 8'd0, 0, 0, 32'd0);
                row_pos = 6'd0;
                col_pos = 7'd0;
            end
            else if (ch == CH_NEWLINE)
            begin
                next_row(rows);
                col_pos = 7'd0;
            end
            else if (ch == CH_RETURN)
                col_pos = 7'd0;
            else if (ch == CH_BACKSPACE)
            begin
                if (col_pos > 0)
                    col_pos = col_pos - 7'd1;
            end
            else if (ch == CH_TAB)
            begin
                // pad with spaces up to the next stop, the last column or four cells
                c = col_pos;
                k = 0;
                do
                begin
                    add_cmd(CMD_DRAW, CH_SPACE, c, row_pos, fg_color);
                    k++;
                    c++;
                end
                while (k < 4 && c < cols && (c % TAB_STOP) != 0);
                col_pos = (c > COL_MAX) ? COL_MAX : 7'(c);
            end
            else
            begin
                add_cmd(CMD_DRAW, ch, col_pos, row_pos, fg_color);
                c = col_pos + 1;
                if (c >= cols)
                begin
                    col_pos = 7'd0;
                    next_row(rows);
                end
                else
                    col_pos = (c > COL_MAX) ? COL_MAX : 7'(c);
            end
            if (owed_cmds.size() > n0)
                owed_cmds[owed_cmds.size() - 1].last = 1'b1;
        endfunction

        // accepted result: compare with the oldest owed command
        function void check_cmd(cmd_rec_t got);
            cmd_rec_t want;
            if (owed_cmds.size() == 0)
            begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected command %0d glyph %02h at col %0d row %0d",
                             got.cmd, got.glyph, got.col, got.row);
                return;
            end
            want = owed_cmds.pop_front();
            if (got.cmd !== want.cmd || got.glyph !== want.glyph || got.col !== want.col ||
                got.row !== want.row || got.fg !== want.fg || got.bg !== want.bg ||
                got.last !== want.last)
            begin
                n_fail++;
                if (n_fail <= 10)
                begin
                    $display("mismatch exp: cmd %0d glyph %02h col %0d row %0d fg %08h bg %08h last %0b",
                             want.cmd, want.glyph, want.col, want.row, want.fg, want.bg,
                             want.last);
                    $display("         got: cmd %0d glyph %02h col %0d row %0d fg %08h bg %08h last %0b",
                             got.cmd, got.glyph, got.col, got.row, got.fg, got.bg, got.last);
                end
            end
        endfunction

        function int owed_count();
            return owed_cmds.size();
        endfunction

    endclass

endpackage

FILE: dv/tb_top.sv
// Testbench top: drives items and register writes into the console cursor controller
`timescale 1ns / 1ps
module tb_top;

    import tccc_pkg::*;
    import tccc_tb_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        push       = 1'b0;
    logic        full;
    logic [1:0]  kind       = 2'd0;
    logic [7:0]  char_code  = 8'd0;
    logic [5:0]  target_row = 6'd0;
    logic [6:0]  target_col = 7'd0;
    logic        empty;
    logic        pop        = 1'b0;
    logic [1:0]  command;
    logic [7:0]  glyph_code;
    logic [6:0]  cell_col;
    logic [5:0]  cell_row;
    logic [31:0] draw_fg;
    logic [31:0] draw_bg;
    logic        last;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index  = 3'd0;
    logic [31:0] cfg_data   = 32'd0;

    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    cursor_cmd_tracker tracker = new();
    cmd_rec_t          seen;

    text_console_cursor_control_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .char_code  (char_code),
        .target_row (target_row),
        .target_col (target_col),
        .empty      (empty),
        .pop        (pop),
        .command    (command),
        .glyph_code (glyph_code),
        .cell_col   (cell_col),
        .cell_row   (cell_row),
        .draw_fg    (draw_fg),
        .draw_bg    (draw_bg),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
                pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // result transfer check
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            seen.cmd   = command_t'(command);
            seen.glyph = glyph_code;
            seen.col   = cell_col;
            seen.row   = cell_row;
            seen.fg    = draw_fg;
            seen.bg    = draw_bg;
            seen.last  = last;
            tracker.check_cmd(seen);
        end
    end

    // offer one item, with random idle cycles first; push stays high after the transfer
    task automatic send_item(logic [1:0] k, logic [7:0] ch, logic [5:0] r, logic [6:0] c);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        kind       <= k;
        char_code  <= ch;
        target_row <= r;
        target_col <= c;
        @(posedge clk);
        while (full)
            @(posedge clk);
        tracker.note_item(k, ch, r, c);
    endtask

    task automatic send_char(logic [7:0] ch);
        send_item(KIND_CHAR, ch, 6'($urandom), 7'($urandom));
    endtask

    task automatic move_to(logic [5:0] r, logic [6:0] c);
        send_item(KIND_MOVE, 8'($urandom), r, c);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        push <= 1'b0;
    endtask

    // wait for every owed command, then for the block's own latency
    task automatic settle();
        stop_sending();
        while (tracker.owed_count() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_screen(logic en, logic [7:0] cols, logic [5:0] rows,
                              logic [31:0] fg, logic [31:0] bg);
        settle();
        write_reg(REG_ENABLED, {31'd0, en});
        write_reg(REG_TEXT_COLS, {24'd0, cols});
        write_reg(REG_TEXT_ROWS, {26'd0, rows});
        write_reg(REG_FG_COLOR, fg);
        write_reg(REG_BG_COLOR, bg);
    endtask

    // random mix weighted towards characters, with move rows and columns near the top left half the time
    task automatic send_random(int n);
        int sel;
        logic [5:0] r;
        logic [6:0] c;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            r   = ($urandom_range(1) == 0) ? 6'($urandom) : 6'($urandom_range(7));
            c   = ($urandom_range(1) == 0) ? 7'($urandom) : 7'($urandom_range(15));
            if (sel < 42)
                send_char(8'($urandom));
            else if (sel < 52)
                send_char(CH_NEWLINE);
            else if (sel < 57)
                send_char(CH_RETURN);
            else if (sel < 62)
                send_char(CH_BACKSPACE);
            else if (sel < 75)
                send_char(CH_TAB);
            else if (sel < 87)
                move_to(r, c);
            else if (sel < 94)
                send_item(KIND_CLEAR, 8'($urandom), 6'($urandom), 7'($urandom));
            else
                send_item(KIND_UNUSED, 8'($urandom), 6'($urandom), 7'($urandom));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // display not yet enabled: character and clear do nothing, move still lands
        send_char(8'h41);
        send_item(KIND_CLEAR, 8'h00, 6'd0, 7'd0);
        move_to(6'd1, 7'd2);

        // small screen, directed cases
        set_screen(1'b1, 8'd8, 6'd3, 32'hFFFF_FFFF, 32'h0000_0000);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(CH_BACKSPACE);
        send_char(CH_RETURN);
        send_char(CH_BACKSPACE);
        send_char(CH_TAB);
        send_char(CH_TAB);
        send_char(8'h78);
        send_char(CH_NEWLINE);
        move_to(6'd2, 7'd5);
        send_char(CH_TAB);
        move_to(6'd63, 7'd127);
        send_char(8'h5A);
        move_to(6'd0, 7'd127);
        send_char(CH_TAB);
        move_to(6'd0, 7'd7);
        send_char(CH_TAB);
        send_item(KIND_CLEAR, 8'hFF, 6'd63, 7'd127);
        send_item(KIND_UNUSED, 8'h41, 6'd5, 7'd5);
        send_char(8'h51);

        // no idling
        set_screen(1'b1, 8'd16, 6'd4, 32'($urandom), 32'($urandom));
        send_random(40);

        // widest register values, sender idle
        send_idle_pct = 57;
        pop_stall_pct = 0;
        set_screen(1'b1, 8'd255, 6'd63, 32'h0000_0000, 32'hFFFF_FFFF);
        send_random(40);

        // zero rows and columns, receiver stalls
        send_idle_pct = 0;
        pop_stall_pct = 57;
        set_screen(1'b1, 8'd0, 6'd0, 32'($urandom), 32'($urandom));
        send_random(35);

        // single row, both sides idle
        send_idle_pct = 27;
        pop_stall_pct = 27;
        set_screen(1'b1, 8'd5, 6'd1, 32'hFFFF_FFFF, 32'h0000_0000);
        send_random(40);

        // disabled again
        set_screen(1'b0, 8'd16, 6'd4, 32'($urandom), 32'($urandom));
        send_random(15);

        // full size screen: long receiver hold-off while items keep coming
        send_idle_pct = 0;
        pop_stall_pct = 0;
        set_screen(1'b1, 8'd128, 6'd48, 32'($urandom), 32'($urandom));
        @(posedge clk);
        hold_left = 400;
        send_random(30);

        // sender pauses until everything has drained
        stop_sending();
        while (tracker.owed_count() != 0)
            @(posedge clk);
        pop_stall_pct = 57;
        send_random(20);

        // drain and finish
        stop_sending();
        while (tracker.owed_count() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.n_fail == 0 && tracker.owed_count() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/tccc_pkg.sv
design/tccc_front.sv
design/tccc_queue.sv
design/tccc_back.sv
design/text_console_cursor_control_core.sv
dv/tccc_tb_pkg.sv
dv/tb_top.sv
